// File: src/bhrt_pkg.sv
// Shared types and constants for the button hold relay toggler.
// Used by the lane, merge and top-level modules; depends on nothing.
package bhrt_pkg;

  // Default number of buttons handled by one block.
  localparam int unsigned NumButtonsDef = 4;

  // Register widths.
  localparam int unsigned HoldW     = 16;
  localparam int unsigned DebounceW = 10;
  localparam int unsigned SettleW   = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned TimeW     = 32;

  // Register reset values.
  localparam logic [HoldW-1:0]     HoldMinRst  = HoldW'(1000);
  localparam logic [HoldW-1:0]     HoldMaxRst  = HoldW'(3000);
  localparam logic [DebounceW-1:0] DebounceRst = DebounceW'(50);
  // Relay pulse of 800 ms plus 200 ms of margin.
  localparam logic [SettleW-1:0]   SettleRst   = SettleW'(800 + 200);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_HOLD_MIN = 2'd0,
    REG_HOLD_MAX = 2'd1,
    REG_DEBOUNCE = 2'd2,
    REG_SETTLE   = 2'd3
  } reg_idx_e;

  // Timing thresholds seen by every lane.
  typedef struct packed {
    logic [HoldW-1:0]     hold_min;
    logic [HoldW-1:0]     hold_max;
    logic [DebounceW-1:0] debounce;
  } lane_cfg_t;

  // Multi-press lock information handed from the merge stage to one lane.
  typedef struct packed {
    logic multi_ok;     // two or more buttons were pressed before the scan
    logic fire_before;  // the lock fired at a lower button
    logic fire_after;   // the lock fires at a higher button
    logic first;        // the lock fires at this button
  } lane_ctl_t;

  // Per-button findings of one scan.
  typedef struct packed {
    logic press;
    logic release_ev;
    logic toggle;
    logic beep;
    logic stuck;
  } lane_res_t;

endpackage

// File: src/bhrt_lane.sv
// One button lane: debounce, hold timing, lock and beep state of one button.
// Depends on bhrt_pkg for the configuration, control and result structs.
module bhrt_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    upd_i,
  input  logic [31:0]             now_i,
  input  logic                    down_i,
  input  bhrt_pkg::lane_cfg_t     cfg_i,
  input  bhrt_pkg::lane_ctl_t     ctl_i,
  output logic                    pressed_o,
  output logic                    elig_o,
  output bhrt_pkg::lane_res_t     res_o
);
  import bhrt_pkg::*;

  logic             pressed_q, pressed_d;
  logic             locked_q, locked_d;
  logic             beeped_q, beeped_d;
  logic [TimeW-1:0] press_time_q, edge_time_q;

  logic [TimeW-1:0] since_edge, held;
  logic db_ok, ge_min, ge_max, active;
  logic press, rel, stuck, beep, toggle, lock_in, lock_own, pressed_after;

  // Elapsed times since the last accepted edge and since the press.
  assign since_edge = now_i - edge_time_q;
  assign held       = now_i - press_time_q;
  assign db_ok      = since_edge >= TimeW'(cfg_i.debounce);
  assign ge_min     = held >= TimeW'(cfg_i.hold_min);
  assign ge_max     = held >= TimeW'(cfg_i.hold_max);

  // Held, pressed and unlocked: a candidate for the multi-press lock.
  assign active = down_i & pressed_q & ~locked_q;
  assign elig_o    = active;
  assign pressed_o = pressed_q;

  // Accepted edges.
  assign press = down_i & ~pressed_q & db_ok;
  assign rel   = ~down_i & pressed_q & db_ok;

  // Hold timing only applies when at most one button was pressed.
  assign stuck = ~ctl_i.multi_ok & active & ge_max;
  assign beep  = ~ctl_i.multi_ok & active & ~ge_max & ge_min & ~beeped_q;

  // A lock fired at a lower button catches this button if it was pressed.
  assign lock_in = locked_q | (ctl_i.fire_before & pressed_q);
  assign toggle  = rel & ~lock_in & ge_min & ~ge_max;

  // Next flag values, including a lock that fires at a higher button.
  always_comb begin
    pressed_after = press | (pressed_q & ~rel);
    lock_own      = (press | rel) ? 1'b0 : (lock_in | stuck);
    pressed_d     = pressed_after;
    locked_d      = lock_own | (ctl_i.fire_after & pressed_after) | ctl_i.first;
    beeped_d      = (press | rel) ? 1'b0 : (beeped_q | beep);
  end

  assign res_o.press      = press;
  assign res_o.release_ev = rel;
  assign res_o.toggle     = toggle;
  assign res_o.beep       = beep;
  assign res_o.stuck      = stuck;

  // Lane state, updated on every scan that is not skipped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q    <= 1'b0;
      locked_q     <= 1'b0;
      beeped_q     <= 1'b0;
      press_time_q <= '0;
      edge_time_q  <= '0;
    end else if (upd_i) begin
      pressed_q <= pressed_d;
      locked_q  <= locked_d;
      beeped_q  <= beeped_d;
      if (press) begin
        press_time_q <= now_i;
      end
      if (press | rel) begin
        edge_time_q <= now_i;
      end
    end
  end

endmodule

// File: src/bhrt_merge.sv
// Merge stage: decides where the multi-press lock fires across the lanes.
// Depends on bhrt_pkg for the lane control struct.
module bhrt_merge #(
  parameter int unsigned NumButtons = bhrt_pkg::NumButtonsDef
) (
  input  logic [NumButtons-1:0]   pressed_i,
  input  logic [NumButtons-1:0]   elig_i,
  output bhrt_pkg::lane_ctl_t     ctl_o [NumButtons],
  output logic                    multi_o
);
  import bhrt_pkg::*;

  logic                  seen_one, two_up;
  logic [NumButtons-1:0] fire, seen_incl;
  logic                  seen;

  // At least two buttons pressed before the scan.
  always_comb begin
    seen_one = 1'b0;
    two_up   = 1'b0;
    for (int i = 0; i < NumButtons; i++) begin
      two_up   = two_up | (seen_one & pressed_i[i]);
      seen_one = seen_one | pressed_i[i];
    end
  end

  assign fire = elig_i & {NumButtons{two_up}};

  // Lowest firing lane wins; lanes above it see the lock already set.
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < NumButtons; i++) begin
      ctl_o[i].multi_ok    = two_up;
      ctl_o[i].fire_before = seen;
      ctl_o[i].first       = fire[i] & ~seen;
      seen                 = seen | fire[i];
      seen_incl[i]         = seen;
    end
    for (int i = 0; i < NumButtons; i++) begin
      ctl_o[i].fire_after = seen & ~seen_incl[i];
    end
  end

  assign multi_o = |fire;

endmodule

// File: src/button_hold_relay_toggler.sv
// Button hold relay toggler top level: configuration, lanes, merge, output register.
// Depends on bhrt_pkg, bhrt_lane and bhrt_merge.
//
// Each scan transfer (timestamp plus button levels) yields exactly one result
// transfer. A scan is evaluated in the cycle it is accepted: one lane per button
// debounces and times its button, the merge stage resolves the multi-press lock,
// and the result lands in the output register at the same edge, so a new scan is
// taken every cycle as long as the output side drains. While a result waits in the
// output register the input is held off; the next scan enters in the same cycle
// that the waiting result transfers out. Configuration writes take effect at the
// next edge and must be made while no scan is in flight; the block does not
// enforce this.
module button_hold_relay_toggler #(
  parameter int unsigned  NumButtons = bhrt_pkg::NumButtonsDef,
  localparam int unsigned InW        = ((32 + NumButtons + 7) / 8) * 8,
  localparam int unsigned OutW       = ((6 * NumButtons + 2 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [bhrt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bhrt_pkg::CfgDataW-1:0] cfg_data_i,
  // Scan input: now_ms, buttons_down.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InW-1:0]                s_axis_tdata,
  // Result: press_events, release_events, toggle_mask, hold_beep_mask,
  // stuck_error_mask, multi_error, relay_on, scan_skipped.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutW-1:0]               m_axis_tdata
);
  import bhrt_pkg::*;

  logic [HoldW-1:0]     hold_min_q, hold_max_q;
  logic [DebounceW-1:0] debounce_q;
  logic [SettleW-1:0]   settle_q;
  logic [NumButtons-1:0] relay_q, relay_d;
  logic [TimeW-1:0]      settle_end_q, settle_end_d;
  logic                  m_valid_q;
  logic [OutW-1:0]       m_data_q, m_data_d;

  logic [TimeW-1:0]      now;
  logic [NumButtons-1:0] levels;
  logic [TimeW-1:0]      since_settle;
  logic                  in_xfer, skip, upd, multi;
  lane_cfg_t             lane_cfg;
  lane_ctl_t             ctl [NumButtons];
  lane_res_t             res [NumButtons];
  logic [NumButtons-1:0] pressed, elig, press_m, rel_m, tog_m, beep_m, stuck_m;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_min_q <= HoldMinRst;
      hold_max_q <= HoldMaxRst;
      debounce_q <= DebounceRst;
      settle_q   <= SettleRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_HOLD_MIN: hold_min_q <= cfg_data_i[HoldW-1:0];
        REG_HOLD_MAX: hold_max_q <= cfg_data_i[HoldW-1:0];
        REG_DEBOUNCE: debounce_q <= cfg_data_i[DebounceW-1:0];
        REG_SETTLE:   settle_q   <= cfg_data_i[SettleW-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cfg.hold_min = hold_min_q;
  assign lane_cfg.hold_max = hold_max_q;
  assign lane_cfg.debounce = debounce_q;

  // Input unpacking and the settle window check.
  assign now          = s_axis_tdata[TimeW-1:0];
  assign levels       = s_axis_tdata[TimeW +: NumButtons];
  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign in_xfer      = s_axis_tvalid & s_axis_tready;
  assign since_settle = now - settle_end_q;
  assign skip         = since_settle[TimeW-1];
  assign upd          = in_xfer & ~skip;

  // One lane per button.
  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    bhrt_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .upd_i     (upd),
      .now_i     (now),
      .down_i    (levels[g]),
      .cfg_i     (lane_cfg),
      .ctl_i     (ctl[g]),
      .pressed_o (pressed[g]),
      .elig_o    (elig[g]),
      .res_o     (res[g])
    );
    assign press_m[g] = res[g].press & ~skip;
    assign rel_m[g]   = res[g].release_ev & ~skip;
    assign tog_m[g]   = res[g].toggle & ~skip;
    assign beep_m[g]  = res[g].beep & ~skip;
    assign stuck_m[g] = res[g].stuck & ~skip;
  end

  bhrt_merge #(
    .NumButtons (NumButtons)
  ) u_merge (
    .pressed_i (pressed),
    .elig_i    (elig),
    .ctl_o     (ctl),
    .multi_o   (multi)
  );

  // Relay latches and the settle window end.
  assign relay_d      = relay_q ^ tog_m;
  assign settle_end_d = now + TimeW'(settle_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q      <= '0;
      settle_end_q <= '0;
    end else if (upd) begin
      relay_q <= relay_d;
      if (|tog_m) begin
        settle_end_q <= settle_end_d;
      end
    end
  end

  // Result packing, lowest field first.
  assign m_data_d = OutW'({skip, relay_d, multi & ~skip, stuck_m, beep_m, tog_m, rel_m,
                           press_m});

  // Output register: a new result loads whenever a scan transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_xfer) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
